>>> rtl/tpts_pkg.sv
// shared types, codes and constants of the tick priority task scheduler
package tpts_pkg;

    // default number of task slots
    localparam int MAX_TASKS_DEF = 8;

    // item modes
    localparam logic [1:0] MODE_ADD  = 2'd0;
    localparam logic [1:0] MODE_TICK = 2'd1;
    localparam logic [1:0] MODE_DONE = 2'd2;

    // result status codes
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_USED     = 2'd1;
    localparam logic [1:0] STAT_NO_READY = 2'd2;
    localparam logic [1:0] STAT_NO_CUR   = 2'd3;

    // countdown limits
    localparam logic signed [15:0] COUNT_MIN = 16'sh8000;
    localparam logic signed [15:0] COUNT_MAX = 16'sh7FFF;

    // one slot table entry
    typedef struct packed {
        logic [7:0]         prio;
        logic [14:0]        period;
        logic signed [15:0] countdown;
    } slot_entry_t;

    localparam int SLOT_ENTRY_W = $bits(slot_entry_t);

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADD_ORD,
        ST_ADD_SLT,
        ST_ADD_CMP,
        ST_TICK,
        ST_TICK_LAST,
        ST_DONE_RD,
        ST_DONE_WR,
        ST_SEL,
        ST_RESP
    } state_t;

endpackage

>>> rtl/tpts_ram.sv
// generic single write port, single read port ram with registered read
module tpts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/tick_priority_task_scheduler_unit.sv
// fixed priority periodic task scheduler: slot table and priority order list in ram
//
// Every item gives exactly one result. Slot data (priority, period, countdown) lives in
// one ram, the priority-ordered list of used slots in a second; both have one read and
// one write port with a registered read, and every operation is a sequence of reads
// and write-backs through them. A refused add (slot used, out of range or table full),
// a done without a current task and the unused mode go straight to the response. An
// add writes the slot entry, then walks the order list from the tail, moving back every
// entry of lower priority, and puts the new slot behind the first entry of equal or
// higher priority, or at the head of the list. A tick walks all MAX_TASKS slots through
// the slot ram, one a cycle, and decrements the countdown of each used slot; a
// task-done adds the period to the current task's countdown in a read-modify-write;
// both then run a selection. A selection streams the order list through both rams
// and ends at the first listed slot whose countdown is zero or negative, if any. The
// result is then placed in an output register; a new item is taken as soon as the
// sequencer is idle, even while that result still waits for m_ready.
module tick_priority_task_scheduler_unit
    import tpts_pkg::*;
#(
    parameter int MAX_TASKS = MAX_TASKS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    // item input
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_mode,
    input  logic [2:0]         s_slot,
    input  logic [7:0]         s_priority_req,
    input  logic [14:0]        s_period,
    input  logic signed [15:0] s_start_count,
    // result output
    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_current_slot,
    output logic               m_switched,
    output logic [1:0]         m_status
);

    localparam int SW   = $clog2(MAX_TASKS);
    localparam int CNTW = $clog2(MAX_TASKS + 1);
    localparam int CW   = (SW > 3) ? SW : 3;

    state_t state_reg, state_next;

    logic [MAX_TASKS-1:0] slot_used_reg, slot_used_next;
    logic [CNTW-1:0]      task_count_reg, task_count_next;
    logic [SW-1:0]        running_slot_reg, running_slot_next;
    logic                 running_valid_reg, running_valid_next;

    logic [SW-1:0] add_slot_reg, add_slot_next;
    logic [7:0]    add_prio_reg, add_prio_next;
    logic [SW-1:0] ins_pos_reg, ins_pos_next;
    logic [SW-1:0] ins_hold_reg, ins_hold_next;

    logic [SW-1:0] tick_idx_reg, tick_idx_next;
    logic          wb_v_reg, wb_v_next;
    logic [SW-1:0] wb_idx_reg, wb_idx_next;

    logic [SW-1:0] sel_pos_reg, sel_pos_next;
    logic          issue_done_reg, issue_done_next;
    logic          s1_v_reg, s1_v_next;
    logic          s1_last_reg, s1_last_next;
    logic          s2_v_reg, s2_v_next;
    logic          s2_last_reg, s2_last_next;
    logic [SW-1:0] s2_slot_reg, s2_slot_next;

    logic [1:0] res_status_reg, res_status_next;
    logic       res_switched_reg, res_switched_next;

    logic       m_valid_reg, m_valid_next;
    logic [2:0] m_current_slot_reg, m_current_slot_next;
    logic       m_switched_reg, m_switched_next;
    logic [1:0] m_status_reg, m_status_next;

    // ram ports
    logic                    slot_we;
    logic [SW-1:0]           slot_waddr, slot_raddr;
    slot_entry_t             slot_wentry, slot_rentry;
    logic [SLOT_ENTRY_W-1:0] slot_rdata;
    logic                    ord_we;
    logic [SW-1:0]           ord_waddr, ord_raddr, ord_wdata, ord_rdata;

    // decoded input and helpers
    logic              accept;
    logic [CW-1:0]     slot_ext;
    logic [SW-1:0]     in_idx;
    logic              in_range;
    logic              add_ok;
    logic              out_free;
    logic              sel_hit;
    logic              sel_miss;
    logic              sel_issue;
    logic              sel_is_last;
    logic              tick_is_last;
    logic signed [16:0] done_sum;
    logic signed [15:0] done_count;
    logic signed [15:0] tick_count;
    logic [CW-1:0]     run_ext;

    assign slot_rentry = slot_entry_t'(slot_rdata);

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign slot_ext = CW'(s_slot);
    assign in_idx   = slot_ext[SW-1:0];
    assign in_range = ({29'd0, s_slot} < MAX_TASKS);
    assign add_ok   = in_range && !slot_used_reg[in_idx]
                      && (task_count_reg < CNTW'(MAX_TASKS));
    assign out_free = !m_valid_reg || m_ready;

    // selection pipeline: hit at the second stage ends the walk
    assign sel_hit     = (state_reg == ST_SEL) && s2_v_reg
                         && (slot_rentry.countdown[15] || (slot_rentry.countdown == 16'sd0));
    assign sel_miss    = (state_reg == ST_SEL)
                         && ((task_count_reg == '0) || (s2_v_reg && s2_last_reg && !sel_hit));
    assign sel_issue   = (state_reg == ST_SEL) && !issue_done_reg && (task_count_reg != '0);
    assign sel_is_last = ((CNTW'(sel_pos_reg) + CNTW'(1)) == task_count_reg);

    assign tick_is_last = (tick_idx_reg == SW'(MAX_TASKS - 1));

    // saturating countdown updates
    assign done_sum   = {slot_rentry.countdown[15], slot_rentry.countdown}
                        + $signed({2'b00, slot_rentry.period});
    assign done_count = (done_sum > $signed({1'b0, COUNT_MAX})) ? COUNT_MAX : done_sum[15:0];
    assign tick_count = (slot_rentry.countdown == COUNT_MIN) ? COUNT_MIN
                        : slot_rentry.countdown - 16'sd1;

    assign run_ext = CW'(running_slot_reg);

    // slot table
    tpts_ram #(
        .WIDTH (SLOT_ENTRY_W),
        .DEPTH (MAX_TASKS)
    ) u_slot_ram (
        .aclk  (aclk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wentry),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    // priority order list
    tpts_ram #(
        .WIDTH (SW),
        .DEPTH (MAX_TASKS)
    ) u_order_ram (
        .aclk  (aclk),
        .we    (ord_we),
        .waddr (ord_waddr),
        .wdata (ord_wdata),
        .raddr (ord_raddr),
        .rdata (ord_rdata)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_mode)
                        MODE_ADD:  state_next = add_ok ? ST_ADD_ORD : ST_RESP;
                        MODE_TICK: state_next = ST_TICK;
                        MODE_DONE: state_next = running_valid_reg ? ST_DONE_RD : ST_RESP;
                        default:   state_next = ST_RESP;
                    endcase
                end
            end
            ST_ADD_ORD: begin
                state_next = (ins_pos_reg == '0) ? ST_RESP : ST_ADD_SLT;
            end
            ST_ADD_SLT: state_next = ST_ADD_CMP;
            ST_ADD_CMP: begin
                state_next = (add_prio_reg >= slot_rentry.prio) ? ST_RESP : ST_ADD_ORD;
            end
            ST_TICK:      state_next = tick_is_last ? ST_TICK_LAST : ST_TICK;
            ST_TICK_LAST: state_next = ST_SEL;
            ST_DONE_RD:   state_next = ST_DONE_WR;
            ST_DONE_WR:   state_next = ST_SEL;
            ST_SEL: begin
                if (sel_hit || sel_miss) begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath, ram controls and register next values
    always_comb begin
        slot_used_next      = slot_used_reg;
        task_count_next     = task_count_reg;
        running_slot_next   = running_slot_reg;
        running_valid_next  = running_valid_reg;
        add_slot_next       = add_slot_reg;
        add_prio_next       = add_prio_reg;
        ins_pos_next        = ins_pos_reg;
        ins_hold_next       = ins_hold_reg;
        tick_idx_next       = '0;
        wb_v_next           = 1'b0;
        wb_idx_next         = tick_idx_reg;
        sel_pos_next        = '0;
        issue_done_next     = 1'b0;
        s1_v_next           = 1'b0;
        s1_last_next        = sel_is_last;
        s2_v_next           = 1'b0;
        s2_last_next        = s1_last_reg;
        s2_slot_next        = ord_rdata;
        res_status_next     = res_status_reg;
        res_switched_next   = res_switched_reg;
        m_valid_next        = m_valid_reg && !m_ready;
        m_current_slot_next = m_current_slot_reg;
        m_switched_next     = m_switched_reg;
        m_status_next       = m_status_reg;

        slot_we     = 1'b0;
        slot_waddr  = in_idx;
        slot_wentry = slot_rentry;
        slot_raddr  = '0;
        ord_we      = 1'b0;
        ord_waddr   = ins_pos_reg;
        ord_wdata   = add_slot_reg;
        ord_raddr   = '0;

        case (state_reg)
            // decode the item, write a new slot entry at once
            ST_IDLE: begin
                if (accept) begin
                    res_switched_next = 1'b0;
                    res_status_next   = STAT_OK;
                    add_slot_next     = in_idx;
                    add_prio_next     = s_priority_req;
                    ins_pos_next      = task_count_reg[SW-1:0];
                    case (s_mode)
                        MODE_ADD: begin
                            if (add_ok) begin
                                slot_we                  = 1'b1;
                                slot_waddr               = in_idx;
                                slot_wentry.prio         = s_priority_req;
                                slot_wentry.period       = s_period;
                                slot_wentry.countdown    = s_start_count;
                                slot_used_next[in_idx]   = 1'b1;
                                task_count_next          = task_count_reg + CNTW'(1);
                            end else begin
                                res_status_next = STAT_USED;
                            end
                        end
                        MODE_DONE: begin
                            if (!running_valid_reg) begin
                                res_status_next = STAT_NO_CUR;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            // insertion from the tail: read the entry in front, or write the new slot at the head
            ST_ADD_ORD: begin
                ord_raddr = ins_pos_reg - SW'(1);
                if (ins_pos_reg == '0) begin
                    ord_we    = 1'b1;
                    ord_waddr = '0;
                    ord_wdata = add_slot_reg;
                end
            end
            ST_ADD_SLT: begin
                slot_raddr    = ord_rdata;
                ins_hold_next = ord_rdata;
            end
            // stop behind equal or higher priority, else move the entry back
            ST_ADD_CMP: begin
                ord_we    = 1'b1;
                ord_waddr = ins_pos_reg;
                if (add_prio_reg >= slot_rentry.prio) begin
                    ord_wdata = add_slot_reg;
                end else begin
                    ord_wdata    = ins_hold_reg;
                    ins_pos_next = ins_pos_reg - SW'(1);
                end
            end
            // tick: stream all slots, write each back in the cycle after its read
            ST_TICK, ST_TICK_LAST: begin
                slot_raddr    = tick_idx_reg;
                tick_idx_next = tick_idx_reg + SW'(1);
                wb_v_next     = (state_reg == ST_TICK);
                if (wb_v_reg && slot_used_reg[wb_idx_reg]) begin
                    slot_we               = 1'b1;
                    slot_waddr            = wb_idx_reg;
                    slot_wentry           = slot_rentry;
                    slot_wentry.countdown = tick_count;
                end
            end
            // done: add the period to the current countdown
            ST_DONE_RD: begin
                slot_raddr = running_slot_reg;
            end
            ST_DONE_WR: begin
                slot_we               = 1'b1;
                slot_waddr            = running_slot_reg;
                slot_wentry           = slot_rentry;
                slot_wentry.countdown = done_count;
            end
            // selection walk over the order list
            ST_SEL: begin
                ord_raddr       = sel_pos_reg;
                slot_raddr      = ord_rdata;
                s1_v_next       = sel_issue;
                s2_v_next       = s1_v_reg;
                sel_pos_next    = sel_pos_reg + SW'(1);
                issue_done_next = issue_done_reg || (sel_issue && sel_is_last);
                if (sel_hit) begin
                    res_status_next    = STAT_OK;
                    res_switched_next  = !running_valid_reg
                                         || (running_slot_reg != s2_slot_reg);
                    running_slot_next  = s2_slot_reg;
                    running_valid_next = 1'b1;
                end else if (sel_miss) begin
                    res_status_next   = STAT_NO_READY;
                    res_switched_next = 1'b0;
                end
            end
            // hand the result to the output register
            ST_RESP: begin
                if (out_free) begin
                    m_valid_next        = 1'b1;
                    m_current_slot_next = running_valid_reg ? run_ext[2:0] : 3'd0;
                    m_switched_next     = res_switched_reg;
                    m_status_next       = res_status_reg;
                end
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            slot_used_reg     <= '0;
            task_count_reg    <= '0;
            running_slot_reg  <= '0;
            running_valid_reg <= 1'b0;
            wb_v_reg          <= 1'b0;
            issue_done_reg    <= 1'b0;
            s1_v_reg          <= 1'b0;
            s2_v_reg          <= 1'b0;
            m_valid_reg       <= 1'b0;
        end else begin
            state_reg         <= state_next;
            slot_used_reg     <= slot_used_next;
            task_count_reg    <= task_count_next;
            running_slot_reg  <= running_slot_next;
            running_valid_reg <= running_valid_next;
            wb_v_reg          <= wb_v_next;
            issue_done_reg    <= issue_done_next;
            s1_v_reg          <= s1_v_next;
            s2_v_reg          <= s2_v_next;
            m_valid_reg       <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        add_slot_reg       <= add_slot_next;
        add_prio_reg       <= add_prio_next;
        ins_pos_reg        <= ins_pos_next;
        ins_hold_reg       <= ins_hold_next;
        tick_idx_reg       <= tick_idx_next;
        wb_idx_reg         <= wb_idx_next;
        sel_pos_reg        <= sel_pos_next;
        s1_last_reg        <= s1_last_next;
        s2_last_reg        <= s2_last_next;
        s2_slot_reg        <= s2_slot_next;
        res_status_reg     <= res_status_next;
        res_switched_reg   <= res_switched_next;
        m_current_slot_reg <= m_current_slot_next;
        m_switched_reg     <= m_switched_next;
        m_status_reg       <= m_status_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_current_slot = m_current_slot_reg;
    assign m_switched     = m_switched_reg;
    assign m_status       = m_status_reg;

endmodule
